>>> src/ptrs_pkg.sv
package ptrs_pkg;

    localparam int DEF_NUM_SLOTS   = 8;
    localparam int DEF_COUNT_WIDTH = 16;

    // Fixed field widths of the stream items.
    localparam int OP_W        = 3;
    localparam int SLOT_W      = 3;
    localparam int TICKS_W     = 16;
    localparam int ISTATE_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_SUSPEND  = 3'd1;
    localparam logic [OP_W-1:0] OP_RESTART  = 3'd2;
    localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_DLY  = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd5;
    localparam logic [OP_W-1:0] OP_DISPATCH = 3'd6;

    localparam logic [ISTATE_W-1:0] ST_DORMANT   = 2'd0;
    localparam logic [ISTATE_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [ISTATE_W-1:0] ST_READY     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec_cmd;
        logic walk_step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_walk;
        logic out_free;
        logic rel;
        logic pend;
        logic walk_done;
    } t_dp_sts;

endpackage

>>> src/periodic_task_release_scheduler_core.sv
// Periodic task release scheduler.
// Requests enter on the slave stream: tuser carries the operation code, tdata
// the slot, period, start delay, preemptive flag and initial state. Results
// leave on the master stream, one per released slot in ascending slot order
// (a single empty one if a walk releases none), or a single result for every
// other request; tlast marks the final result of a request. The APB port holds
// the run flag at address 0; ticks change nothing while it is clear.
// A slot command is latched when accepted, applied to its slot once the output
// register is free, and its result is registered there. A tick or dispatch
// walks the slot table one slot per cycle unless a further release waits for
// the output register. A new request is taken once the previous one has
// produced its last result into the output register, even while that result
// still waits. When the receiver stalls, the output register holds its result
// and a walk that finds a further release waits in place until the register
// frees. After reset all slots are empty and dormant, the add count is zero
// and the scheduler is stopped.
module periodic_task_release_scheduler_core
    import ptrs_pkg::*;
#(
    parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // slot[2:0], period_ticks[18:3], delay_ticks[34:19], preemptive[35],
    // initial_state[37:36], zero[39:38]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // op[2:0]
    input  logic [OP_W-1:0]        i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // released[0], released_slot[3:1], status[4], zero[7:5]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [APB_AW-1:0]      i_paddr,
    input  logic [APB_DW-1:0]      i_pwdata,
    output logic [APB_DW-1:0]      o_prdata,
    output logic                   o_pready
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_pready = 1'b1;

    ptrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    ptrs_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata)
    );

endmodule

>>> src/ptrs_ctrl.sv
module ptrs_ctrl
    import ptrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.is_walk) begin
                    if (i_sts.out_free) begin
                        o_cmd.exec_cmd = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (!(i_sts.rel && i_sts.pend && !i_sts.out_free)) begin
                    // A second release can only move on once the output register is free to take the held one.
                    o_cmd.walk_step = 1'b1;
                    if (i_sts.walk_done) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/ptrs_datapath.sv
module ptrs_datapath
    import ptrs_pkg::*;
#(
    parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic [IN_TDATA_W-1:0]   i_s_tdata,
    input  logic [OP_W-1:0]         i_s_tuser,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                    o_m_tlast,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [APB_AW-1:0]       i_paddr,
    input  logic [APB_DW-1:0]       i_pwdata,
    output logic [APB_DW-1:0]       o_prdata
);

    localparam int SIW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNTW = $clog2(NUM_SLOTS + 1);
    localparam int CW   = COUNT_WIDTH;

    // Configuration register.
    logic r_running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
            r_running <= i_pwdata[0];
        end
    end

    assign o_prdata = i_paddr[2] ? '0 : {{(APB_DW-1){1'b0}}, r_running};

    // Latched request.
    logic [OP_W-1:0]     r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic [TICKS_W-1:0]  r_period;
    logic [TICKS_W-1:0]  r_delay;
    logic                r_pre;
    logic [ISTATE_W-1:0] r_istate;
    logic                r_is_walk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_walk <= 1'b0;
        end else if (i_cmd.load) begin
            r_is_walk <= ((i_s_tuser == OP_TICK) && r_running) || (i_s_tuser == OP_DISPATCH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_s_tuser;
            r_slot   <= i_s_tdata[2:0];
            r_period <= i_s_tdata[18:3];
            r_delay  <= i_s_tdata[34:19];
            r_pre    <= i_s_tdata[35];
            r_istate <= i_s_tdata[37:36];
        end
    end

    // Slot table.
    logic              r_present [NUM_SLOTS];
    logic [1:0]        r_st      [NUM_SLOTS];
    logic [CW-1:0]     r_per     [NUM_SLOTS];
    logic [CW-1:0]     r_dly     [NUM_SLOTS];
    logic [CW-1:0]     r_pcnt    [NUM_SLOTS];
    logic [CW:0]       r_dcnt    [NUM_SLOTS];
    logic              r_preempt [NUM_SLOTS];
    logic [CNTW-1:0]   r_added;

    // Walk state.
    logic [SIW-1:0] r_idx;
    logic           r_pend;
    logic [SIW-1:0] r_pend_slot;

    logic [31:0]    slot_ext;
    logic           slot_ok;
    logic [SIW-1:0] cmd_idx;
    logic [SIW-1:0] rd_idx;
    logic           full;

    assign slot_ext = 32'(r_slot);
    assign slot_ok  = (slot_ext < 32'(NUM_SLOTS));
    assign cmd_idx  = slot_ext[SIW-1:0];
    assign rd_idx   = r_is_walk ? r_idx : cmd_idx;
    assign full     = (r_added >= CNTW'(NUM_SLOTS));

    logic          cur_present;
    logic [1:0]    cur_st;
    logic [CW-1:0] cur_per;
    logic [CW-1:0] cur_dly;
    logic [CW-1:0] cur_pcnt;
    logic [CW:0]   cur_dcnt;
    logic          cur_preempt;

    assign cur_present = r_present[rd_idx];
    assign cur_st      = r_st[rd_idx];
    assign cur_per     = r_per[rd_idx];
    assign cur_dly     = r_dly[rd_idx];
    assign cur_pcnt    = r_pcnt[rd_idx];
    assign cur_dcnt    = r_dcnt[rd_idx];
    assign cur_preempt = r_preempt[rd_idx];

    logic          n_present;
    logic [1:0]    n_st;
    logic [CW-1:0] n_per;
    logic [CW-1:0] n_dly;
    logic [CW-1:0] n_pcnt;
    logic [CW:0]   n_dcnt;
    logic          n_preempt;
    logic          rel;
    logic          add_ok;
    logic          status;
    logic [CW-1:0] pinc;

    assign pinc   = cur_pcnt + 1'b1;
    assign status = (r_op == OP_ADD) && full;

    always_comb begin
        n_present = cur_present;
        n_st      = cur_st;
        n_per     = cur_per;
        n_dly     = cur_dly;
        n_pcnt    = cur_pcnt;
        n_dcnt    = cur_dcnt;
        n_preempt = cur_preempt;
        rel       = 1'b0;
        add_ok    = 1'b0;
        if (r_is_walk) begin
            if (cur_present) begin
                if (r_op == OP_TICK) begin
                    if (cur_st == ST_NOT_READY) begin
                        if (cur_dcnt <= {1'b0, cur_dly}) begin
                            if (cur_dcnt == {1'b0, cur_dly}) begin
                                n_st = ST_READY;
                            end
                            n_dcnt = cur_dcnt + 1'b1;
                        end else if (cur_per == '0) begin
                            n_pcnt = '0;
                            n_st   = ST_READY;
                        end else begin
                            n_pcnt = pinc;
                            if (pinc == cur_per) begin
                                n_pcnt = '0;
                                n_st   = ST_READY;
                            end
                        end
                        if ((n_st == ST_READY) && cur_preempt) begin
                            n_st = ST_NOT_READY;
                            rel  = 1'b1;
                        end
                    end
                end else if (cur_st == ST_READY) begin
                    n_st = ST_NOT_READY;
                    rel  = 1'b1;
                end
            end
        end else if (slot_ok) begin
            priority case (r_op)
                OP_ADD: begin
                    if (!full) begin
                        add_ok    = 1'b1;
                        n_present = 1'b1;
                        n_per     = CW'(r_period);
                        n_dly     = CW'(r_delay);
                        n_preempt = r_pre;
                        n_st      = (r_istate == 2'd3) ? ST_DORMANT : r_istate;
                    end
                end
                OP_SUSPEND: begin
                    n_st = ST_DORMANT;
                end
                OP_RESTART, OP_SET_DLY: begin
                    n_st   = ST_NOT_READY;
                    n_pcnt = '0;
                    n_dcnt = '0;
                    if (r_op == OP_SET_DLY) begin
                        n_dly = CW'(r_delay);
                    end
                end
                OP_ACTIVATE: begin
                    n_st   = ST_NOT_READY;
                    n_pcnt = '0;
                    n_dcnt = {1'b0, cur_dly};
                end
                default: begin
                end
            endcase
        end
    end

    logic wr_en;
    assign wr_en = (i_cmd.exec_cmd && !r_is_walk) || i_cmd.walk_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_present[i] <= 1'b0;
                r_st[i]      <= ST_DORMANT;
                r_per[i]     <= '0;
                r_dly[i]     <= '0;
                r_pcnt[i]    <= '0;
                r_dcnt[i]    <= '0;
                r_preempt[i] <= 1'b0;
            end
            r_added <= '0;
        end else begin
            if (wr_en) begin
                r_present[rd_idx] <= n_present;
                r_st[rd_idx]      <= n_st;
                r_per[rd_idx]     <= n_per;
                r_dly[rd_idx]     <= n_dly;
                r_pcnt[rd_idx]    <= n_pcnt;
                r_dcnt[rd_idx]    <= n_dcnt;
                r_preempt[rd_idx] <= n_preempt;
            end
            if (i_cmd.exec_cmd && add_ok) begin
                r_added <= r_added + 1'b1;
            end
        end
    end

    // Slot walk: one slot per step, the latest release is held until the next
    // one or the end of the walk tells whether it is the last result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_idx <= r_idx + 1'b1;
            if (rel) begin
                r_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && rel) begin
            r_pend_slot <= r_idx;
        end
    end

    // Output register.
    logic       r_out_valid;
    logic       r_out_rel;
    logic [2:0] r_out_slot;
    logic       r_out_status;
    logic       r_out_last;
    logic [31:0] pend_ext;

    assign pend_ext = 32'(r_pend_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec_cmd || i_cmd.finish || (i_cmd.walk_step && rel && r_pend)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_cmd) begin
            r_out_rel    <= 1'b0;
            r_out_slot   <= '0;
            r_out_status <= status;
            r_out_last   <= 1'b1;
        end else if (i_cmd.finish) begin
            r_out_rel    <= r_pend;
            r_out_slot   <= r_pend ? pend_ext[2:0] : 3'd0;
            r_out_status <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.walk_step && rel && r_pend) begin
            r_out_rel    <= 1'b1;
            r_out_slot   <= pend_ext[2:0];
            r_out_status <= 1'b0;
            r_out_last   <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_status, r_out_slot, r_out_rel};
    assign o_m_tlast  = r_out_last;

    assign o_sts.is_walk   = r_is_walk;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_sts.rel       = rel;
    assign o_sts.pend      = r_pend;
    assign o_sts.walk_done = (r_idx == SIW'(NUM_SLOTS - 1));

endmodule

>>> src/ptrs_checker.sv
module ptrs_checker
    import ptrs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tlast,
    input logic                   o_pready
);

    // A held result stays on offer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // Only one request is in work at a time.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while another is in work");

    // A result that releases nothing carries slot zero.
    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[3:1] == 3'd0)
        else $error("empty result carries a slot id");

    // A rejected add is a single, final, non-release result.
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[4] |-> o_m_tlast && !o_m_tdata[0])
        else $error("rejected add result malformed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pready)
        else $error("pready low");

endmodule

bind periodic_task_release_scheduler_core ptrs_checker u_ptrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_pready   (o_pready)
);
